### design/ucdp_pkg.sv
// Shared types, constants and the attribute length table for the UCD parser.
`timescale 1ns / 1ps

package ucdp_pkg;

  // Parse phases, one per position in the message structure
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_TTYPE  = 3'd1,
    PH_TLEN   = 3'd2,
    PH_TVAL   = 3'd3,
    PH_IUC    = 3'd4,
    PH_ITYPE  = 3'd5,
    PH_ILEN   = 3'd6,
    PH_IVAL   = 3'd7
  } ucdp_phase_t;

  // Result kinds
  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_CHAN = 2'd1;
  localparam logic [1:0] KIND_ATTR = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  // Top-level record types
  localparam logic [7:0] TLV_SYM_RATE = 8'd1;
  localparam logic [7:0] TLV_FREQ     = 8'd2;
  localparam logic [7:0] TLV_PREAMBLE = 8'd3;
  localparam logic [7:0] TLV_BURST_V1 = 8'd4;
  localparam logic [7:0] TLV_BURST_V2 = 8'd5;

  localparam logic [31:0] SYM_RATE_SCALE = 32'd160;
  localparam logic [7:0]  HDR_BYTES      = 8'd4;
  localparam logic [7:0]  SYM_RATE_LEN   = 8'd1;

  // Highest known attribute type per descriptor form
  localparam logic [7:0] ATTR_LIMIT_V1 = 8'd11;
  localparam logic [7:0] ATTR_LIMIT_V2 = 8'd14;

  // Expected attribute value length by type; top entry is unused
  localparam logic [1:0] ATTR_LEN_TAB [16] = '{
    2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd1, 2'd2,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd1, 2'd0
  };

  // One result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  code;
    logic [7:0]  usage_code;
    logic        version_two;
    logic [31:0] value;
    logic [7:0]  byte_index;
    logic        length_error;
    logic        truncated;
    logic        last;
  } ucdp_result_t;

  // Expected length of a burst attribute, 0 when the type is unknown
  function automatic logic [1:0] attr_expected(input logic [7:0] t, input logic v2);
    logic [7:0] limit;
    logic [1:0] len;
    limit = v2 ? ATTR_LIMIT_V2 : ATTR_LIMIT_V1;
    if (t == 8'd0 || t > limit) begin
      len = 2'd0;
    end else begin
      len = ATTR_LEN_TAB[t[3:0]];
    end
    return len;
  endfunction

endpackage

### design/ucdp_in_if.sv
// Byte request channel into the UCD parser.
`timescale 1ns / 1ps

interface ucdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       message_end;

  modport source (output valid, output data_byte, output message_end, input ready);
  modport sink   (input valid, input data_byte, input message_end, output ready);
endinterface

### design/ucdp_out_if.sv
// Result request channel out of the UCD parser.
`timescale 1ns / 1ps

interface ucdp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  code;
  logic [7:0]  usage_code;
  logic        version_two;
  logic [31:0] value;
  logic [7:0]  byte_index;
  logic        length_error;
  logic        truncated;
  logic        last;

  modport source (output valid, output kind, output code, output usage_code,
                  output version_two, output value, output byte_index,
                  output length_error, output truncated, output last, input ready);
  modport sink   (input valid, input kind, input code, input usage_code,
                  input version_two, input value, input byte_index,
                  input length_error, input truncated, input last, output ready);
endinterface

### design/ucdp_core.sv
// Parse state machine: one byte per accepted request, at most one result.
`timescale 1ns / 1ps

module ucdp_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic [7:0]            data_byte,
  input  logic                  message_end,
  output logic                  push,
  output ucdp_pkg::ucdp_result_t res
);
  import ucdp_pkg::*;

  ucdp_phase_t phase_r, phase_nxt;
  logic [1:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]  otype_r, otype_nxt;
  logic [7:0]  orem_r, orem_nxt;
  logic [7:0]  itype_r, itype_nxt;
  logic [7:0]  irem_r, irem_nxt;
  logic [7:0]  iuc_r, iuc_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        skip_r, skip_nxt;

  logic        have;
  logic        ver2;
  logic [7:0]  orem_dec;
  logic [7:0]  irem_dec;
  logic [7:0]  want_top;
  logic [1:0]  want_attr;
  logic [31:0] shifted;
  ucdp_result_t r;

  assign ver2     = (otype_r == TLV_BURST_V2);
  assign orem_dec = orem_r - 8'd1;
  assign irem_dec = irem_r - 8'd1;
  assign shifted  = {acc_r[23:0], data_byte};
  assign want_top = (otype_r == TLV_SYM_RATE) ? SYM_RATE_LEN : HDR_BYTES;
  assign want_attr = attr_expected(itype_r, ver2);

  // Next state and result for the byte on the input
  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    otype_nxt   = otype_r;
    orem_nxt    = orem_r;
    itype_nxt   = itype_r;
    irem_nxt    = irem_r;
    iuc_nxt     = iuc_r;
    acc_nxt     = acc_r;
    skip_nxt    = skip_r;
    have        = 1'b0;
    r           = '0;

    unique case (phase_r)
      PH_HEADER: begin
        have        = 1'b1;
        r.kind      = KIND_HDR;
        r.code      = {6'd0, hdr_cnt_r};
        r.value     = {24'd0, data_byte};
        hdr_cnt_nxt = hdr_cnt_r + 2'd1;
        if (hdr_cnt_r == 2'd3) begin
          phase_nxt = PH_TTYPE;
        end
      end
      PH_TTYPE: begin
        otype_nxt = data_byte;
        phase_nxt = PH_TLEN;
      end
      PH_TLEN: begin
        orem_nxt = data_byte;
        skip_nxt = 1'b0;
        acc_nxt  = '0;
        if (otype_r == TLV_SYM_RATE || otype_r == TLV_FREQ) begin
          if (data_byte != want_top) begin
            have           = 1'b1;
            r.kind         = KIND_CHAN;
            r.code         = otype_r;
            r.length_error = 1'b1;
            skip_nxt       = 1'b1;
          end
        end else if (otype_r == TLV_BURST_V1 || otype_r == TLV_BURST_V2) begin
          if (data_byte == 8'd0) begin
            have           = 1'b1;
            r.kind         = KIND_CHAN;
            r.code         = otype_r;
            r.length_error = 1'b1;
          end
        end else if (otype_r != TLV_PREAMBLE) begin
          skip_nxt = 1'b1;
        end
        if (data_byte == 8'd0) begin
          phase_nxt = PH_TTYPE;
        end else if (otype_r == TLV_BURST_V1 || otype_r == TLV_BURST_V2) begin
          phase_nxt = PH_IUC;
        end else begin
          phase_nxt = PH_TVAL;
        end
      end
      PH_TVAL: begin
        orem_nxt = orem_dec;
        if (!skip_r) begin
          if (otype_r == TLV_SYM_RATE) begin
            have    = 1'b1;
            r.kind  = KIND_CHAN;
            r.code  = TLV_SYM_RATE;
            r.value = {24'd0, data_byte} * SYM_RATE_SCALE;
          end else if (otype_r == TLV_FREQ) begin
            acc_nxt = shifted;
            if (orem_dec == 8'd0) begin
              have    = 1'b1;
              r.kind  = KIND_CHAN;
              r.code  = TLV_FREQ;
              r.value = shifted;
            end
          end else if (otype_r == TLV_PREAMBLE) begin
            have         = 1'b1;
            r.kind       = KIND_CHAN;
            r.code       = TLV_PREAMBLE;
            r.value      = {24'd0, data_byte};
            r.byte_index = acc_r[7:0];
            acc_nxt      = {24'd0, acc_r[7:0] + 8'd1};
          end
        end
        if (orem_dec == 8'd0) begin
          phase_nxt = PH_TTYPE;
        end
      end
      PH_IUC: begin
        iuc_nxt       = data_byte;
        orem_nxt      = orem_dec;
        have          = 1'b1;
        r.kind        = KIND_CHAN;
        r.code        = otype_r;
        r.usage_code  = data_byte;
        r.version_two = ver2;
        r.value       = {24'd0, data_byte};
        phase_nxt     = (orem_dec == 8'd0) ? PH_TTYPE : PH_ITYPE;
      end
      PH_ITYPE: begin
        itype_nxt = data_byte;
        orem_nxt  = orem_dec;
        phase_nxt = (orem_dec == 8'd0) ? PH_TTYPE : PH_ILEN;
      end
      PH_ILEN: begin
        irem_nxt = data_byte;
        acc_nxt  = '0;
        orem_nxt = orem_dec;
        skip_nxt = (want_attr == 2'd0) || ({6'd0, want_attr} != data_byte);
        if (want_attr != 2'd0 && {6'd0, want_attr} != data_byte) begin
          have           = 1'b1;
          r.kind         = KIND_ATTR;
          r.code         = itype_r;
          r.usage_code   = iuc_r;
          r.version_two  = ver2;
          r.length_error = 1'b1;
        end
        if (orem_dec == 8'd0) begin
          phase_nxt = PH_TTYPE;
        end else if (data_byte == 8'd0) begin
          phase_nxt = PH_ITYPE;
        end else begin
          phase_nxt = PH_IVAL;
        end
      end
      PH_IVAL: begin
        acc_nxt  = shifted;
        irem_nxt = irem_dec;
        orem_nxt = orem_dec;
        if (irem_dec == 8'd0 && !skip_r) begin
          have          = 1'b1;
          r.kind        = KIND_ATTR;
          r.code        = itype_r;
          r.usage_code  = iuc_r;
          r.version_two = ver2;
          r.value       = shifted;
        end
        if (orem_dec == 8'd0) begin
          phase_nxt = PH_TTYPE;
        end else if (irem_dec == 8'd0) begin
          phase_nxt = PH_ITYPE;
        end
      end
    endcase

    // End of message: close out, or give a bare end marker
    if (message_end && !have) begin
      r      = '0;
      r.kind = KIND_END;
    end
    r.truncated = message_end && (phase_nxt != PH_TTYPE);
    r.last      = message_end;
  end

  assign push = take && (have || message_end);
  assign res  = r;

  // Parse state registers; a closing byte returns everything to reset
  always_ff @(posedge clk) begin
    if (!rst_n || (take && message_end)) begin
      phase_r   <= PH_HEADER;
      hdr_cnt_r <= '0;
      otype_r   <= '0;
      orem_r    <= '0;
      itype_r   <= '0;
      irem_r    <= '0;
      iuc_r     <= '0;
      acc_r     <= '0;
      skip_r    <= 1'b0;
    end else if (take) begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      otype_r   <= otype_nxt;
      orem_r    <= orem_nxt;
      itype_r   <= itype_nxt;
      irem_r    <= irem_nxt;
      iuc_r     <= iuc_nxt;
      acc_r     <= acc_nxt;
      skip_r    <= skip_nxt;
    end
  end

`ifndef SYNTHESIS
  // A closing byte always leaves the parser at the start of a header
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    take && message_end |=> phase_r == PH_HEADER && hdr_cnt_r == 2'd0)
    else $error("parser not reset after message end");

  // Header count only moves while in the header phase
  a_hdr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_cnt_r != 2'd0 |-> phase_r == PH_HEADER)
    else $error("header count set outside header phase");

  // An attribute value phase always has bytes left to take
  a_ival_rem: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IVAL |-> irem_r != 8'd0)
    else $error("attribute value phase with no bytes left");
`endif

endmodule

### design/ucdp_out_buf.sv
// Result register with a skid stage, so input stays open while a result waits.
`timescale 1ns / 1ps

module ucdp_out_buf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  ucdp_pkg::ucdp_result_t push_data,
  output logic                   space,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ucdp_pkg::ucdp_result_t out_data
);
  import ucdp_pkg::*;

  logic         out_valid_r;
  logic         sk_valid_r;
  ucdp_result_t out_data_r;
  ucdp_result_t sk_data_r;
  logic         stall;

  assign stall     = out_valid_r && !out_ready;
  assign space     = !sk_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else if (stall) begin
      if (push) begin
        sk_valid_r <= 1'b1;
      end
    end else if (sk_valid_r) begin
      out_valid_r <= 1'b1;
      sk_valid_r  <= push;
    end else begin
      out_valid_r <= push;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (stall) begin
      if (push) begin
        sk_data_r <= push_data;
      end
    end else if (sk_valid_r) begin
      out_data_r <= sk_data_r;
      if (push) begin
        sk_data_r <= push_data;
      end
    end else if (push) begin
      out_data_r <= push_data;
    end
  end

`ifndef SYNTHESIS
  // The skid stage is only ever filled behind a held result
  a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
    sk_valid_r |-> out_valid_r)
    else $error("skid stage full with result register empty");

  // A request arriving against a stalled result lands in the skid stage
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    stall && push |=> sk_valid_r)
    else $error("result lost while output stalled");

  // A stalled result stays offered and unchanged
  a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result changed or withdrawn");
`endif

endmodule

### design/upstream_channel_descriptor_parser_top.sv
// Top level of the upstream channel descriptor parser.
`timescale 1ns / 1ps

// Takes a descriptor one byte per request and gives at most one result per
// byte: header fields, channel parameters (symbol rate times 160, frequency,
// preamble bytes, burst usage codes) and burst attributes, with length errors
// flagged and a closing result on the byte marked as message end. One byte is
// accepted every cycle while ready is high; its result is registered and shows
// on the output the cycle after acceptance, or later from the skid entry if the
// output is stalled. A result register plus one skid entry let input continue
// for one more byte while the output stalls; ready drops only when both hold.
module upstream_channel_descriptor_parser_top (
  input  logic         clk,
  input  logic         rst_n,
  ucdp_in_if.sink      in_ch,
  ucdp_out_if.source   out_ch
);
  import ucdp_pkg::*;

  logic         take;
  logic         push;
  logic         space;
  ucdp_result_t res;
  ucdp_result_t out_data;

  assign in_ch.ready = space;
  assign take        = in_ch.valid && space;

  ucdp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .data_byte   (in_ch.data_byte),
    .message_end (in_ch.message_end),
    .push        (push),
    .res         (res)
  );

  ucdp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .space     (space),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  // Unpack the registered result onto the channel
  assign out_ch.kind         = out_data.kind;
  assign out_ch.code         = out_data.code;
  assign out_ch.usage_code   = out_data.usage_code;
  assign out_ch.version_two  = out_data.version_two;
  assign out_ch.value        = out_data.value;
  assign out_ch.byte_index   = out_data.byte_index;
  assign out_ch.length_error = out_data.length_error;
  assign out_ch.truncated    = out_data.truncated;
  assign out_ch.last         = out_data.last;

endmodule

### tb/tb_top.sv
// Self-checking testbench for the upstream channel descriptor parser top level.
`timescale 1ns / 1ps

// Directed and random descriptor messages are streamed in one byte per request
// with random gaps, and results are taken with random stalls. A byte-level
// parse model inside a small scoreboard predicts each result, and each result
// is checked field by field in arrival order.
module tb_top;
  import ucdp_pkg::*;

  localparam int          CLK_HALF_NS  = 2;
  localparam int          TIMEOUT_NS   = 2_000_000;
  localparam int          RANDOM_BYTES = 750;
  localparam int          LONG_HOLD    = 300;
  localparam int          TAIL_CYCLES  = 20;
  localparam int          ERR_PRINTS   = 30;
  localparam logic [7:0]  FREQ_BYTES   = 8'd4;
  localparam logic [7:0]  UNKNOWN_TLV  = 8'd9;

  // Burst attribute types with a two-byte value
  localparam logic [7:0] ATTR_PREAMBLE_LEN    = 8'd3;
  localparam logic [7:0] ATTR_PREAMBLE_OFFSET = 8'd4;
  localparam logic [7:0] ATTR_SCRAMBLER_SEED  = 8'd7;
  localparam logic [7:0] ATTR_RS_BLOCK_SIZE   = 8'd13;

  // Parse model and result checker
  class ucd_scoreboard;
    ucdp_phase_t  phase;
    logic [1:0]   hdr_count;
    logic [7:0]   outer_type;
    logic [7:0]   outer_left;
    logic [7:0]   inner_type;
    logic [7:0]   inner_left;
    logic [7:0]   usage;
    logic [31:0]  acc;
    logic         skip;
    ucdp_result_t parse_results_q[$];
    int           errors;
    int           checked;
    int           len_errs;
    int           truncs;

    function new();
      errors   = 0;
      checked  = 0;
      len_errs = 0;
      truncs   = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase      = PH_HEADER;
      hdr_count  = '0;
      outer_type = '0;
      outer_left = '0;
      inner_type = '0;
      inner_left = '0;
      usage      = '0;
      acc        = '0;
      skip       = 1'b0;
    endfunction

    // Expected attribute value length, 0 for a type unknown in this form
    function logic [7:0] attr_len(logic [7:0] t, logic v2);
      if (t == 8'd0 || t > (v2 ? ATTR_LIMIT_V2 : ATTR_LIMIT_V1)) return 8'd0;
      unique case (t)
        ATTR_PREAMBLE_LEN, ATTR_PREAMBLE_OFFSET,
        ATTR_SCRAMBLER_SEED, ATTR_RS_BLOCK_SIZE: return 8'd2;
        default: return 8'd1;
      endcase
    endfunction

    function int pending();
      return parse_results_q.size();
    endfunction

    // Advance the parse by one accepted byte and queue the result it causes
    function void note_byte(logic [7:0] b, logic msg_end);
      ucdp_result_t r;
      bit           have;
      logic         v2;
      logic [7:0]   want;
      r    = '0;
      have = 0;
      v2   = (outer_type == TLV_BURST_V2);
      unique case (phase)
        PH_HEADER: begin
          have      = 1;
          r.kind    = KIND_HDR;
          r.code    = {6'd0, hdr_count};
          r.value   = {24'd0, b};
          hdr_count = hdr_count + 2'd1;
          if (hdr_count == 2'd0) phase = PH_TTYPE;
        end
        PH_TLEN: begin
          outer_left = b;
          skip       = 1'b0;
          acc        = '0;
          if (outer_type == TLV_SYM_RATE || outer_type == TLV_FREQ) begin
            want = (outer_type == TLV_SYM_RATE) ? SYM_RATE_LEN : FREQ_BYTES;
            if (b != want) begin
              have           = 1;
              r.kind         = KIND_CHAN;
              r.code         = outer_type;
              r.length_error = 1'b1;
              skip           = 1'b1;
            end
          end else if (outer_type == TLV_BURST_V1 || outer_type == TLV_BURST_V2) begin
            // empty burst descriptor
            if (b == 8'd0) begin
              have           = 1;
              r.kind         = KIND_CHAN;
              r.code         = outer_type;
              r.length_error = 1'b1;
            end
          end else if (outer_type != TLV_PREAMBLE) begin
            skip = 1'b1;
          end
          if (b == 8'd0) phase = PH_TTYPE;
          else if (outer_type == TLV_BURST_V1 || outer_type == TLV_BURST_V2) phase = PH_IUC;
          else phase = PH_TVAL;
        end
        PH_TVAL: begin
          outer_left = outer_left - 8'd1;
          if (!skip) begin
            if (outer_type == TLV_SYM_RATE) begin
              have    = 1;
              r.kind  = KIND_CHAN;
              r.code  = TLV_SYM_RATE;
              r.value = {24'd0, b} * SYM_RATE_SCALE;
            end else if (outer_type == TLV_FREQ) begin
              acc = {acc[23:0], b};
              if (outer_left == 8'd0) begin
                have    = 1;
                r.kind  = KIND_CHAN;
                r.code  = TLV_FREQ;
                r.value = acc;
              end
            end else if (outer_type == TLV_PREAMBLE) begin
              have         = 1;
              r.kind       = KIND_CHAN;
              r.code       = TLV_PREAMBLE;
              r.value      = {24'd0, b};
              r.byte_index = acc[7:0];
              acc          = {24'd0, acc[7:0] + 8'd1};
            end
          end
          if (outer_left == 8'd0) phase = PH_TTYPE;
        end
        PH_IUC: begin
          usage         = b;
          outer_left    = outer_left - 8'd1;
          have          = 1;
          r.kind        = KIND_CHAN;
          r.code        = outer_type;
          r.usage_code  = b;
          r.version_two = v2;
          r.value       = {24'd0, b};
          phase = (outer_left == 8'd0) ? PH_TTYPE : PH_ITYPE;
        end
        PH_ITYPE: begin
          inner_type = b;
          outer_left = outer_left - 8'd1;
          phase = (outer_left == 8'd0) ? PH_TTYPE : PH_ILEN;
        end
        PH_ILEN: begin
          want       = attr_len(inner_type, v2);
          inner_left = b;
          acc        = '0;
          outer_left = outer_left - 8'd1;
          skip       = (want == 8'd0 || want != b);
          if (want != 8'd0 && want != b) begin
            have           = 1;
            r.kind         = KIND_ATTR;
            r.code         = inner_type;
            r.usage_code   = usage;
            r.version_two  = v2;
            r.length_error = 1'b1;
          end
          if (outer_left == 8'd0) phase = PH_TTYPE;
          else if (b == 8'd0) phase = PH_ITYPE;
          else phase = PH_IVAL;
        end
        PH_IVAL: begin
          acc        = {acc[23:0], b};
          inner_left = inner_left - 8'd1;
          outer_left = outer_left - 8'd1;
          if (inner_left == 8'd0 && !skip) begin
            have          = 1;
            r.kind        = KIND_ATTR;
            r.code        = inner_type;
            r.usage_code  = usage;
            r.version_two = v2;
            r.value       = acc;
          end
          // descriptor length wins over an overrunning attribute
          if (outer_left == 8'd0) phase = PH_TTYPE;
          else if (inner_left == 8'd0) phase = PH_ITYPE;
        end
        default: begin
          outer_type = b;
          phase      = PH_TLEN;
        end
      endcase
      if (!have && !msg_end) return;
      if (!have) begin
        r      = '0;
        r.kind = KIND_END;
      end
      r.truncated = msg_end && (phase != PH_TTYPE);
      r.last      = msg_end;
      parse_results_q.push_back(r);
      if (msg_end) clear_state();
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= ERR_PRINTS)
          $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    // Compare one delivered result with the oldest outstanding one
    function void check_result(ucdp_result_t got);
      ucdp_result_t want;
      if (parse_results_q.size() == 0) begin
        errors++;
        if (errors <= ERR_PRINTS)
          $display("%0t: unexpected result, expected none, got %0h", $time, got);
        return;
      end
      want = parse_results_q.pop_front();
      checked++;
      if (want.length_error) len_errs++;
      if (want.truncated) truncs++;
      cmp("kind",         32'(want.kind),         32'(got.kind));
      cmp("code",         32'(want.code),         32'(got.code));
      cmp("usage_code",   32'(want.usage_code),   32'(got.usage_code));
      cmp("version_two",  32'(want.version_two),  32'(got.version_two));
      cmp("value",        want.value,             got.value);
      cmp("byte_index",   32'(want.byte_index),   32'(got.byte_index));
      cmp("length_error", 32'(want.length_error), 32'(got.length_error));
      cmp("truncated",    32'(want.truncated),    32'(got.truncated));
      cmp("last",         32'(want.last),         32'(got.last));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ucdp_in_if  in_ch();
  ucdp_out_if out_ch();

  upstream_channel_descriptor_parser_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ucd_scoreboard sb = new();
  logic [7:0]    msg_q[$];
  bit            hold_req;
  int            bytes_sent;
  int            msgs_sent;

  // Clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF_NS clk = ~clk;
  end

  // Run limit
  initial begin
    #TIMEOUT_NS;
    $display("TEST FAILED");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Observe both channels at each edge
  always @(posedge clk) begin
    ucdp_result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_byte(in_ch.data_byte, in_ch.message_end);
      if (out_ch.valid && out_ch.ready) begin
        got.kind         = out_ch.kind;
        got.code         = out_ch.code;
        got.usage_code   = out_ch.usage_code;
        got.version_two  = out_ch.version_two;
        got.value        = out_ch.value;
        got.byte_index   = out_ch.byte_index;
        got.length_error = out_ch.length_error;
        got.truncated    = out_ch.truncated;
        got.last         = out_ch.last;
        sb.check_result(got);
      end
    end
  end

  // Result side: random stalls, ready stretches, one long hold on request
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = gap_len();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // Offer one byte and wait until it is taken
  task automatic send_byte(logic [7:0] b, logic msg_end, bit no_gap);
    int gap;
    gap = no_gap ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.message_end <= msg_end;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_message(bit no_gap);
    foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1, no_gap);
    msgs_sent++;
  endtask

  // Withdraw the offer and wait for every outstanding result
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic add_random(int n);
    repeat (n) msg_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Burst descriptor with random attributes, now and then malformed
  task automatic add_burst();
    logic [7:0] body[$];
    logic [7:0] btype;
    logic [7:0] t;
    logic [7:0] want;
    logic [7:0] alen;
    int         olen;
    int         r;
    btype = $urandom_range(0, 1) ? TLV_BURST_V2 : TLV_BURST_V1;
    body.push_back(8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 4)) begin
      t = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 14));
      want = sb.attr_len(t, btype == TLV_BURST_V2);
      alen = (want != 0 && $urandom_range(0, 7) != 0) ? want : 8'($urandom_range(0, 3));
      body.push_back(t);
      body.push_back(alen);
      repeat (alen) body.push_back(8'($urandom_range(0, 255)));
    end
    r = $urandom_range(0, 19);
    if (r == 0) olen = 0;
    else if (r < 4) olen = $urandom_range(1, body.size());
    else olen = body.size();
    msg_q.push_back(btype);
    msg_q.push_back(8'(olen));
    for (int i = 0; i < olen; i++) msg_q.push_back(body[i]);
  endtask

  // Well-formed message with random content, or noise, maybe cut short
  task automatic build_message();
    int r;
    int len;
    msg_q.delete();
    if ($urandom_range(0, 19) == 0) begin
      add_random($urandom_range(1, 30));
      return;
    end
    add_random(4);
    repeat ($urandom_range(1, 6)) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        msg_q.push_back(TLV_SYM_RATE);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : SYM_RATE_LEN;
        msg_q.push_back(8'(len));
        add_random(len);
      end else if (r < 30) begin
        msg_q.push_back(TLV_FREQ);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : FREQ_BYTES;
        msg_q.push_back(8'(len));
        add_random(len);
      end else if (r < 45) begin
        msg_q.push_back(TLV_PREAMBLE);
        len = ($urandom_range(0, 49) == 0) ? $urandom_range(128, 255) : $urandom_range(0, 8);
        msg_q.push_back(8'(len));
        add_random(len);
      end else if (r < 90) begin
        add_burst();
      end else begin
        // unknown top-level type, skipped silently
        do len = $urandom_range(0, 255);
        while (len >= TLV_SYM_RATE && len <= TLV_BURST_V2);
        msg_q.push_back(8'(len));
        len = $urandom_range(0, 6);
        msg_q.push_back(8'(len));
        add_random(len);
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, msg_q.size() - 1);
      while (msg_q.size() > len) void'(msg_q.pop_back());
    end
  endtask

  // Main sequence
  initial begin
    int random_start;
    bytes_sent = 0;
    msgs_sent  = 0;
    hold_req   = 0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.data_byte   <= '0;
    in_ch.message_end <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, v2 attribute, overrunning attribute, zero and
    // wrong lengths, attribute length error, unknown type, truncated end
    msg_q = '{8'h00, 8'hFF, 8'h80, 8'h7F,
              TLV_FREQ, FREQ_BYTES, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
              TLV_SYM_RATE, SYM_RATE_LEN, 8'hFF,
              TLV_BURST_V2, 8'd6, 8'hAA, ATTR_RS_BLOCK_SIZE, 8'd2, 8'h12, 8'h34,
              ATTR_PREAMBLE_LEN,
              TLV_SYM_RATE, 8'd0,
              TLV_BURST_V1, 8'd3, 8'h55, ATTR_SCRAMBLER_SEED, 8'd1,
              UNKNOWN_TLV, 8'd2, 8'hAB};
    send_message(0);
    msg_q = '{8'h01, 8'h02, 8'h03, 8'h04, TLV_BURST_V1, 8'd0};
    send_message(1);
    wait_drained();

    // Random messages
    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      if (msgs_sent == 4) hold_req = 1;
      if (msgs_sent % 10 == 0) wait_drained();
      build_message();
      send_message($urandom_range(0, 3) == 0);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d bytes in %0d messages; %0d results checked.",
             bytes_sent, msgs_sent, sb.checked);
    $display("Among them %0d length errors and %0d truncated messages.",
             sb.len_errs, sb.truncs);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
design/ucdp_pkg.sv
design/ucdp_in_if.sv
design/ucdp_out_if.sv
design/ucdp_core.sv
design/ucdp_out_buf.sv
design/upstream_channel_descriptor_parser_top.sv
tb/tb_top.sv
